FILE: rtl/core/pipd_pkg.sv
`timescale 1ns / 1ps
package pipd_pkg;

  // Window length default
  localparam int WINDOW_SAMPLES_DEF = 31;

  // Field widths
  localparam int TIME_W  = 16;
  localparam int SMALL_W = 15;
  localparam int SUM_W   = 32;
  localparam int AVG_SHIFT = 5;
  localparam int AVG_W   = SUM_W - AVG_SHIFT;
  localparam int CFG_W   = 16;

  // Register indexes
  localparam logic [1:0] REG_AVG_LIMIT = 2'd0;
  localparam logic [1:0] REG_SERVO_MIN = 2'd1;
  localparam logic [1:0] REG_SERVO_MAX = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] AVG_LIMIT_RST = 16'd50;
  localparam logic [CFG_W-1:0] SERVO_MIN_RST = 16'd300;
  localparam logic [CFG_W-1:0] SERVO_MAX_RST = 16'd20000;

  // Smallest interval start value
  localparam logic [SMALL_W-1:0] SMALLEST_START = 15'd20000;

  // Mode codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_DSHOT = 2'd1;
  localparam logic [1:0] MODE_SERVO = 2'd2;

  // Capture settings
  localparam logic [5:0] CAP_PRESCALE_RST = 6'd10;
  localparam logic [5:0] CAP_PRESCALE_FAST = 6'd0;
  localparam logic [5:0] CAP_PRESCALE_SLOW = 6'd1;
  localparam logic [5:0] SERVO_PRESCALE = 6'd47;
  localparam logic [5:0] SERVO_ARM = 6'd35;
  localparam logic [5:0] CAPTURE_FULL = 6'd32;
  localparam logic [5:0] SERVO_LENGTH = 6'd2;
  localparam logic [3:0] FAST_PAD = 4'd9;
  localparam logic [3:0] SLOW_PAD = 4'd7;

  // Summary of one closed window
  typedef struct packed {
    logic [SMALL_W-1:0] least;
    logic [SUM_W-1:0]   sum;
  } win_sum_t;

  // One result word
  typedef struct packed {
    logic [1:0]         detected_mode;
    logic               input_set;
    logic [5:0]         capture_prescaler;
    logic               output_prescaler;
    logic [3:0]         send_padding;
    logic [5:0]         capture_length;
    logic [5:0]         arm_threshold;
    logic               preset_counter;
    logic [SMALL_W-1:0] smallest_interval;
    logic [AVG_W-1:0]   average_interval;
  } res_t;

endpackage

FILE: rtl/core/pipd_accum.sv
`timescale 1ns / 1ps
module pipd_accum #(
  parameter int WINDOW_SAMPLES = pipd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pipd_pkg::TIME_W-1:0]   in_capture_time,
  input  logic                          res_busy,
  input  logic                          win_take,
  output logic                          win_valid,
  output pipd_pkg::win_sum_t            win_sum
);

  localparam int IDX_W = $clog2(WINDOW_SAMPLES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);

  logic [IDX_W-1:0]               idx_r;
  logic [pipd_pkg::TIME_W-1:0]    prev_r;
  logic [pipd_pkg::SMALL_W-1:0]   small_r, small_nxt;
  logic [pipd_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic                           win_valid_r;
  pipd_pkg::win_sum_t             win_sum_r;

  logic                           accept, last, wrap, upd;
  logic [pipd_pkg::TIME_W-1:0]    diff;
  logic [pipd_pkg::SUM_W-1:0]     diff_ext;

  // Hold the closing word back only while both result slots are taken
  assign last     = (idx_r == LAST_IDX);
  assign in_stall = win_valid_r & res_busy & last;
  assign accept   = in_valid & ~in_stall;

  // Modular difference: a timer wrap sign-fills the upper half
  assign wrap     = (in_capture_time < prev_r);
  assign diff     = in_capture_time - prev_r;
  assign diff_ext = {{(pipd_pkg::SUM_W - pipd_pkg::TIME_W){wrap}}, diff};
  assign upd      = (idx_r != '0) && (diff != '0);

  // Update smallest interval and running sum
  always_comb begin
    small_nxt = small_r;
    sum_nxt   = sum_r;
    if (upd) begin
      sum_nxt = sum_r + diff_ext;
      if (!wrap && (diff < {1'b0, small_r})) begin
        small_nxt = diff[pipd_pkg::SMALL_W-1:0];
      end
    end
  end

  // Advance the window on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      prev_r      <= '0;
      small_r     <= pipd_pkg::SMALLEST_START;
      sum_r       <= '0;
      win_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_r <= in_capture_time;
        if (last) begin
          idx_r   <= '0;
          small_r <= pipd_pkg::SMALLEST_START;
          sum_r   <= '0;
        end else begin
          idx_r   <= idx_r + 1'b1;
          small_r <= small_nxt;
          sum_r   <= sum_nxt;
        end
      end
      if (accept && last) begin
        win_valid_r <= 1'b1;
      end else if (win_take) begin
        win_valid_r <= 1'b0;
      end
    end
  end

  // Latch the closed window summary
  always_ff @(posedge clk) begin
    if (accept && last) begin
      win_sum_r.least <= small_nxt;
      win_sum_r.sum   <= sum_nxt;
    end
  end

  assign win_valid = win_valid_r;
  assign win_sum   = win_sum_r;

endmodule

FILE: rtl/core/pipd_classify.sv
`timescale 1ns / 1ps
module pipd_classify (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pipd_pkg::CFG_W-1:0]    avg_limit,
  input  logic [pipd_pkg::CFG_W-1:0]    servo_min,
  input  logic [pipd_pkg::CFG_W-1:0]    servo_max,
  input  logic                          win_valid,
  input  pipd_pkg::win_sum_t            win_sum,
  output logic                          win_take,
  output logic                          res_busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pipd_pkg::res_t                res
);

  logic                           dshot_r, servo_r, flag_r, oprs_r;
  logic [5:0]                     cprs_r, len_r;
  logic [3:0]                     pad_r;
  logic                           dshot_nxt, servo_nxt, flag_nxt, oprs_nxt;
  logic [5:0]                     cprs_nxt, len_nxt;
  logic [3:0]                     pad_nxt;
  logic                           out_valid_r;
  pipd_pkg::res_t                 res_r, res_nxt;

  logic [pipd_pkg::AVG_W-1:0]     avg;
  logic                           avg_ok, fast, slow, servo_hit;
  logic                           hit_fast, hit_slow, hit_servo;

  // Move a window in when the result slot is free or draining
  assign win_take = win_valid & (~out_valid_r | ~out_stall);
  assign res_busy = out_valid_r;

  // Grade checks
  assign avg       = win_sum.sum[pipd_pkg::SUM_W-1:pipd_pkg::AVG_SHIFT];
  assign avg_ok    = (avg < pipd_pkg::AVG_W'(avg_limit));
  assign fast      = (win_sum.least > 15'd1) && (win_sum.least < 15'd4) && avg_ok;
  assign slow      = (win_sum.least >= 15'd4) && (win_sum.least < 15'd8) && avg_ok;
  assign servo_hit = ({1'b0, win_sum.least} > servo_min) &&
                     ({1'b0, win_sum.least} < servo_max);

  // A sticky mode re-runs only its own check
  assign hit_fast  = (dshot_r | ~servo_r) & fast;
  assign hit_slow  = (dshot_r | ~servo_r) & slow;
  assign hit_servo = ~dshot_r & servo_hit;

  // Work out new capture settings; servo overrides the prescaler and length where both apply
  always_comb begin
    dshot_nxt = dshot_r | hit_fast | hit_slow;
    servo_nxt = servo_r | hit_servo;
    flag_nxt  = flag_r | hit_fast | hit_slow | hit_servo;
    cprs_nxt  = cprs_r;
    oprs_nxt  = oprs_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    if (hit_fast) begin
      cprs_nxt = pipd_pkg::CAP_PRESCALE_FAST;
      oprs_nxt = 1'b0;
      pad_nxt  = pipd_pkg::FAST_PAD;
      len_nxt  = pipd_pkg::CAPTURE_FULL;
    end
    if (hit_slow) begin
      cprs_nxt = pipd_pkg::CAP_PRESCALE_SLOW;
      oprs_nxt = 1'b1;
      pad_nxt  = pipd_pkg::SLOW_PAD;
      len_nxt  = pipd_pkg::CAPTURE_FULL;
    end
    if (hit_servo) begin
      cprs_nxt = pipd_pkg::SERVO_PRESCALE;
      len_nxt  = pipd_pkg::SERVO_LENGTH;
    end

    if (dshot_nxt) begin
      res_nxt.detected_mode = pipd_pkg::MODE_DSHOT;
    end else if (servo_nxt) begin
      res_nxt.detected_mode = pipd_pkg::MODE_SERVO;
    end else begin
      res_nxt.detected_mode = pipd_pkg::MODE_NONE;
    end
    res_nxt.input_set         = flag_nxt;
    res_nxt.capture_prescaler = cprs_nxt;
    res_nxt.output_prescaler  = oprs_nxt;
    res_nxt.send_padding      = pad_nxt;
    res_nxt.capture_length    = len_nxt;
    res_nxt.arm_threshold     = hit_servo ? pipd_pkg::SERVO_ARM : 6'd0;
    res_nxt.preset_counter    = hit_slow;
    res_nxt.smallest_interval = win_sum.least;
    res_nxt.average_interval  = avg;
  end

  // Commit settings and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dshot_r     <= 1'b0;
      servo_r     <= 1'b0;
      flag_r      <= 1'b0;
      cprs_r      <= pipd_pkg::CAP_PRESCALE_RST;
      oprs_r      <= 1'b0;
      pad_r       <= 4'd0;
      len_r       <= pipd_pkg::CAPTURE_FULL;
      out_valid_r <= 1'b0;
    end else begin
      if (win_take) begin
        dshot_r     <= dshot_nxt;
        servo_r     <= servo_nxt;
        flag_r      <= flag_nxt;
        cprs_r      <= cprs_nxt;
        oprs_r      <= oprs_nxt;
        pad_r       <= pad_nxt;
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (win_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/core/pulse_input_protocol_detector.sv
`timescale 1ns / 1ps
// Pulse input protocol detector. Accepts one 16-bit edge timestamp per clock
// and groups them in windows of WINDOW_SAMPLES; the first of a window only sets
// the reference time. At the end of each window one result word gives the
// sticky mode (digital-shot or servo) and the capture settings now in force,
// with the smallest interval and the sum of intervals divided by 32. After the
// closing timestamp the word passes the window accumulator register (difference,
// minimum, sum), then the classifier register. Intake runs at one word per cycle;
// it pauses only for a closing timestamp while one result is held at the output
// and another is queued behind it. Registers must be written by the user through
// the cfg_ port while the block is idle; the block itself does not enforce this.
module pulse_input_protocol_detector #(
  parameter int WINDOW_SAMPLES = pipd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [pipd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pipd_pkg::TIME_W-1:0]   in_capture_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_detected_mode,
  output logic                          out_input_set,
  output logic [5:0]                    out_capture_prescaler,
  output logic                          out_output_prescaler,
  output logic [3:0]                    out_send_padding,
  output logic [5:0]                    out_capture_length,
  output logic [5:0]                    out_arm_threshold,
  output logic                          out_preset_counter,
  output logic [pipd_pkg::SMALL_W-1:0]  out_smallest_interval,
  output logic [pipd_pkg::AVG_W-1:0]    out_average_interval
);

  logic [pipd_pkg::CFG_W-1:0] avg_limit_r, servo_min_r, servo_max_r;
  logic                       win_valid, win_take, res_busy;
  pipd_pkg::win_sum_t         win_sum;
  pipd_pkg::res_t             res;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_limit_r <= pipd_pkg::AVG_LIMIT_RST;
      servo_min_r <= pipd_pkg::SERVO_MIN_RST;
      servo_max_r <= pipd_pkg::SERVO_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pipd_pkg::REG_AVG_LIMIT: avg_limit_r <= cfg_data;
        pipd_pkg::REG_SERVO_MIN: servo_min_r <= cfg_data;
        pipd_pkg::REG_SERVO_MAX: servo_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pipd_accum #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_capture_time (in_capture_time),
    .res_busy        (res_busy),
    .win_take        (win_take),
    .win_valid       (win_valid),
    .win_sum         (win_sum)
  );

  pipd_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .avg_limit (avg_limit_r),
    .servo_min (servo_min_r),
    .servo_max (servo_max_r),
    .win_valid (win_valid),
    .win_sum   (win_sum),
    .win_take  (win_take),
    .res_busy  (res_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result word
  assign out_detected_mode     = res.detected_mode;
  assign out_input_set         = res.input_set;
  assign out_capture_prescaler = res.capture_prescaler;
  assign out_output_prescaler  = res.output_prescaler;
  assign out_send_padding      = res.send_padding;
  assign out_capture_length    = res.capture_length;
  assign out_arm_threshold     = res.arm_threshold;
  assign out_preset_counter    = res.preset_counter;
  assign out_smallest_interval = res.smallest_interval;
  assign out_average_interval  = res.average_interval;

endmodule

FILE: tb/sv/pulse_input_protocol_detector_tb.sv
`timescale 1ns / 1ps
module pulse_input_protocol_detector_tb;
  import pipd_pkg::*;

  // Out-of-range register index, writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    SHAPE_FAST,
    SHAPE_SLOW,
    SHAPE_SERVO,
    SHAPE_FLAT,
    SHAPE_NOISE,
    SHAPE_EDGE
  } shape_e;

  // Tracks the window state and the sticky mode, holds the words still owed
  class window_classifier;
    logic [CFG_W-1:0]   avg_limit;
    logic [CFG_W-1:0]   servo_min;
    logic [CFG_W-1:0]   servo_max;
    logic [TIME_W-1:0]  last_stamp;
    logic [SMALL_W-1:0] least;
    logic [SUM_W-1:0]   sum;
    int                 fill;
    bit                 dshot_seen;
    bit                 servo_seen;
    bit                 set_seen;
    logic [5:0]         cap_pre;
    logic               out_pre;
    logic [3:0]         pad;
    logic [5:0]         len;
    bit                 arm_hit;
    bit                 preset_hit;
    res_t               pending_windows[$];
    int                 mismatches;

    function new();
      avg_limit  = AVG_LIMIT_RST;
      servo_min  = SERVO_MIN_RST;
      servo_max  = SERVO_MAX_RST;
      last_stamp = '0;
      least      = SMALLEST_START;
      sum        = '0;
      fill       = 0;
      dshot_seen = 1'b0;
      servo_seen = 1'b0;
      set_seen   = 1'b0;
      cap_pre    = CAP_PRESCALE_RST;
      out_pre    = 1'b0;
      pad        = '0;
      len        = CAPTURE_FULL;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_AVG_LIMIT: avg_limit = val;
        REG_SERVO_MIN: servo_min = val;
        REG_SERVO_MAX: servo_max = val;
        default: ;
      endcase
    endfunction

    // Both digital-shot grades; their interval bands do not overlap
    function void digital_check(logic [SMALL_W-1:0] lo, logic [SUM_W-1:0] avg);
      if (lo > 1 && lo < 4 && avg < {16'd0, avg_limit}) begin
        cap_pre    = CAP_PRESCALE_FAST;
        out_pre    = 1'b0;
        dshot_seen = 1'b1;
        pad        = FAST_PAD;
        len        = CAPTURE_FULL;
        set_seen   = 1'b1;
      end
      if (lo >= 4 && lo < 8 && avg < {16'd0, avg_limit}) begin
        dshot_seen = 1'b1;
        cap_pre    = CAP_PRESCALE_SLOW;
        out_pre    = 1'b1;
        preset_hit = 1'b1;
        pad        = SLOW_PAD;
        len        = CAPTURE_FULL;
        set_seen   = 1'b1;
      end
    endfunction

    function void servo_check(logic [SMALL_W-1:0] lo);
      if ({1'b0, lo} > servo_min && {1'b0, lo} < servo_max) begin
        servo_seen = 1'b1;
        cap_pre    = SERVO_PRESCALE;
        arm_hit    = 1'b1;
        len        = SERVO_LENGTH;
        set_seen   = 1'b1;
      end
    endfunction

    // Accumulate one timestamp; close the window on the last one
    function void take_capture(logic [TIME_W-1:0] stamp);
      logic [SUM_W-1:0] d;
      logic [SUM_W-1:0] avg;
      res_t             w;
      if (fill != 0) begin
        d = {16'd0, stamp} - {16'd0, last_stamp};
        if (d != 0) begin
          if (d < {17'd0, least}) least = d[SMALL_W-1:0];
          sum = sum + d;
        end
      end
      last_stamp = stamp;
      fill++;
      if (fill < WINDOW_SAMPLES_DEF) return;

      avg        = sum >> AVG_SHIFT;
      arm_hit    = 1'b0;
      preset_hit = 1'b0;
      if (dshot_seen) begin
        digital_check(least, avg);
      end else if (servo_seen) begin
        servo_check(least);
      end else begin
        digital_check(least, avg);
        servo_check(least);
      end

      w.detected_mode     = dshot_seen ? MODE_DSHOT : (servo_seen ? MODE_SERVO : MODE_NONE);
      w.input_set         = set_seen;
      w.capture_prescaler = cap_pre;
      w.output_prescaler  = out_pre;
      w.send_padding      = pad;
      w.capture_length    = len;
      w.arm_threshold     = arm_hit ? SERVO_ARM : 6'd0;
      w.preset_counter    = preset_hit;
      w.smallest_interval = least;
      w.average_interval  = avg[AVG_W-1:0];
      pending_windows.push_back(w);

      fill  = 0;
      least = SMALLEST_START;
      sum   = '0;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_window(res_t got);
      res_t want;
      if (pending_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: mode %0d smallest %0d average %0d",
                   got.detected_mode, got.smallest_interval, got.average_interval);
        return;
      end
      want = pending_windows.pop_front();
      compare_field("detected_mode", 32'(want.detected_mode), 32'(got.detected_mode));
      compare_field("input_set", 32'(want.input_set), 32'(got.input_set));
      compare_field("capture_prescaler", 32'(want.capture_prescaler),
                    32'(got.capture_prescaler));
      compare_field("output_prescaler", 32'(want.output_prescaler),
                    32'(got.output_prescaler));
      compare_field("send_padding", 32'(want.send_padding), 32'(got.send_padding));
      compare_field("capture_length", 32'(want.capture_length), 32'(got.capture_length));
      compare_field("arm_threshold", 32'(want.arm_threshold), 32'(got.arm_threshold));
      compare_field("preset_counter", 32'(want.preset_counter), 32'(got.preset_counter));
      compare_field("smallest_interval", 32'(want.smallest_interval),
                    32'(got.smallest_interval));
      compare_field("average_interval", 32'(want.average_interval),
                    32'(got.average_interval));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [TIME_W-1:0]  in_capture_time;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_detected_mode;
  logic               out_input_set;
  logic [5:0]         out_capture_prescaler;
  logic               out_output_prescaler;
  logic [3:0]         out_send_padding;
  logic [5:0]         out_capture_length;
  logic [5:0]         out_arm_threshold;
  logic               out_preset_counter;
  logic [SMALL_W-1:0] out_smallest_interval;
  logic [AVG_W-1:0]   out_average_interval;

  window_classifier tracker = new();

  int hold_cycles = 0;
  bit tx_burst    = 1'b0;
  int tx_quiet    = 0;

  // Extremes, zero interval, full-range step, timer wrap, grade edges
  logic [TIME_W-1:0] directed_stamps [16] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0003, 16'h0006, 16'h000A,
    16'h0011, 16'h0019, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'hFFFE, 16'hFFFE
  };

  pulse_input_protocol_detector #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES_DEF)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_capture_time       (in_capture_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_detected_mode     (out_detected_mode),
    .out_input_set         (out_input_set),
    .out_capture_prescaler (out_capture_prescaler),
    .out_output_prescaler  (out_output_prescaler),
    .out_send_padding      (out_send_padding),
    .out_capture_length    (out_capture_length),
    .out_arm_threshold     (out_arm_threshold),
    .out_preset_counter    (out_preset_counter),
    .out_smallest_interval (out_smallest_interval),
    .out_average_interval  (out_average_interval)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender gap: mostly none, some short, a few long, now and then a quiet run
  function automatic int pick_gap();
    int r;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 95) begin
      tx_quiet = $urandom_range(50, 150);
      return 0;
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return SHAPE_FAST;
    if (r < 40) return SHAPE_SLOW;
    if (r < 60) return SHAPE_SERVO;
    if (r < 65) return SHAPE_FLAT;
    if (r < 80) return SHAPE_NOISE;
    return SHAPE_EDGE;
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg_value(logic [1:0] idx);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    case (idx)
      REG_AVG_LIMIT: return CFG_W'($urandom_range(20, 2000));
      REG_SERVO_MIN: return CFG_W'($urandom_range(0, 1000));
      default:       return CFG_W'($urandom_range(500, 20001));
    endcase
  endfunction

  // Offer one timestamp and hold it until the block takes it
  task automatic send_capture(input logic [TIME_W-1:0] stamp);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_capture_time <= stamp;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    tracker.take_capture(stamp);
  endtask

  // One full window of timestamps built from interval steps of the given shape
  task automatic send_window(input shape_e shape);
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] step;
    int                pin;
    stamp = TIME_W'($urandom_range(0, 65535));
    pin   = $urandom_range(1, WINDOW_SAMPLES_DEF - 1);
    send_capture(stamp);
    for (int i = 1; i < WINDOW_SAMPLES_DEF; i++) begin
      case (shape)
        SHAPE_FAST:
          step = TIME_W'((i == pin) ? $urandom_range(2, 3) :
                 (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(2, 40)));
        SHAPE_SLOW:
          step = TIME_W'((i == pin) ? $urandom_range(4, 7) :
                 (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(4, 40)));
        SHAPE_SERVO: step = TIME_W'($urandom_range(250, 2200));
        SHAPE_EDGE: begin
          case ($urandom_range(0, 11))
            0:       step = 16'd0;
            1:       step = 16'd1;
            2:       step = 16'd2;
            3:       step = 16'd3;
            4:       step = 16'd4;
            5:       step = 16'd7;
            6:       step = 16'd8;
            7:       step = tracker.servo_min;
            8:       step = tracker.servo_min + 16'd1;
            9:       step = tracker.servo_max - 16'd1;
            10:      step = tracker.servo_max;
            default: step = 16'hFFFF;
          endcase
        end
        default: step = '0;
      endcase
      if (shape == SHAPE_NOISE) stamp = TIME_W'($urandom_range(0, 65535));
      else stamp = stamp + step;
      send_capture(stamp);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every owed word, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_windows.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Receiver: forced hold-off first, else random stall and quiet runs
  initial begin : receiver
    bit rx_busy;
    int rx_left;
    int r;
    rx_busy   = 1'b0;
    rx_left   = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (rx_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            rx_busy = 1'b0;
            rx_left = $urandom_range(1, 8);
          end else if (r < 85) begin
            rx_busy = 1'b1;
            rx_left = $urandom_range(1, 3);
          end else if (r < 95) begin
            rx_busy = 1'b0;
            rx_left = $urandom_range(50, 200);
          end else begin
            rx_busy = 1'b1;
            rx_left = $urandom_range(10, 40);
          end
        end
        out_stall <= rx_busy;
        rx_left--;
      end
    end
  end

  // Check every word the receiver takes
  always @(posedge clk) begin : watch
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.detected_mode     = out_detected_mode;
      got.input_set         = out_input_set;
      got.capture_prescaler = out_capture_prescaler;
      got.output_prescaler  = out_output_prescaler;
      got.send_padding      = out_send_padding;
      got.capture_length    = out_capture_length;
      got.arm_threshold     = out_arm_threshold;
      got.preset_counter    = out_preset_counter;
      got.smallest_interval = out_smallest_interval;
      got.average_interval  = out_average_interval;
      tracker.check_window(got);
    end
  end

  initial begin
    #5_000_000;
    $display("[pulse_input_protocol_detector] ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_AVG_LIMIT;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_capture_time = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed window under the reset settings
    for (int i = 0; i < WINDOW_SAMPLES_DEF; i++)
      send_capture(directed_stamps[(i < 16) ? i : 15]);

    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      if (phase == 0) begin
        // Settings under which nothing can be recognised
        write_reg(REG_AVG_LIMIT, '0);
        write_reg(REG_SERVO_MIN, '1);
        write_reg(REG_SERVO_MAX, '0);
        write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
      end else begin
        write_reg(REG_AVG_LIMIT, pick_reg_value(REG_AVG_LIMIT));
        write_reg(REG_SERVO_MIN, pick_reg_value(REG_SERVO_MIN));
        write_reg(REG_SERVO_MAX, pick_reg_value(REG_SERVO_MAX));
        if (phase == 4) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
      end
      for (int w = 0; w < 8; w++) begin
        // Hold the receiver off while windows stream in back to back
        if (phase == 3 && w == 2) begin
          hold_cycles = 300;
          tx_burst    = 1'b1;
        end
        if (phase == 3 && w == 7) tx_burst = 1'b0;
        if (phase == 5 && w == 4) drain_results();
        send_window(pick_shape());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_windows.size() == 0) begin
      $display("[pulse_input_protocol_detector] OK");
    end else begin
      $display("[pulse_input_protocol_detector] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pipd_pkg.sv
rtl/core/pipd_accum.sv
rtl/core/pipd_classify.sv
rtl/core/pulse_input_protocol_detector.sv
tb/sv/pulse_input_protocol_detector_tb.sv
